// ===== design/ltip_pkg.sv =====
package ltip_pkg;

  localparam int POS_W  = 24;
  localparam int FRAC_W = 16;
  localparam int PER_W  = 20;
  localparam int SPD_W  = 24;
  localparam int TIME_W = 32;
  localparam int DIF_W  = POS_W + 1;
  localparam int SQ_W   = 2 * DIF_W;
  localparam int ROOT_W = DIF_W;
  localparam int USEC_W = 20;
  localparam int PROD_W = ROOT_W + USEC_W;
  localparam int T_W    = FRAC_W + 1;
  localparam int LMUL_W = DIF_W + T_W + 1;
  localparam int CNT_W  = 6;

  localparam logic [PER_W-1:0]  PERIOD_DEFAULT = PER_W'(5000);
  localparam logic [SPD_W-1:0]  SPEED_FLOOR    = SPD_W'(10000);
  localparam logic [USEC_W-1:0] USEC_PER_S     = USEC_W'(1000000);
  localparam logic [T_W-1:0]    T_ONE          = T_W'(1) << FRAC_W;

  typedef enum logic [1:0] {
    ACT_SET_POS = 2'd0,
    ACT_SET_TGT = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_TICK    = 2'd3
  } act_e;

  typedef struct packed {
    logic       latch_tgt;
    logic       setpos;
    logic       stop;
    logic       clr_done;
    logic       tick;
    logic       sq;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       mul;
    logic       div_ld_time;
    logic       div_ld_t;
    logic       div_step;
    logic       seg_wr;
    logic       near;
    logic       jump;
    logic       t_one;
    logic       t_quot;
    logic       lerp;
    logic       fin;
    logic       emit;
    logic [1:0] axis;
  } ltip_cmd_t;

  typedef struct packed {
    logic active;
    logic dist_le1;
    logic seg_zero;
    logic el_ge_seg;
  } ltip_sts_t;

endpackage

// ===== design/ltip_ctrl.sv =====
module ltip_ctrl import ltip_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic [1:0] s_tuser_i,
  input  logic       m_tready_i,
  input  ltip_sts_t  sts_i,
  output logic       s_tready_o,
  output logic       m_tvalid_o,
  output ltip_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQI, S_SQRT, S_NEAR, S_DLD, S_DIV, S_SEG,
    S_TCHK, S_TDIV, S_TQ, S_LERP, S_FIN, S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             mvalid_q, mvalid_d;

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = mvalid_q;

  always_comb begin
    cmd_o      = '0;
    cmd_o.axis = cnt_q[1:0];
    state_d    = state_q;
    cnt_d      = cnt_q;
    mvalid_d   = mvalid_q && !m_tready_i;
    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.clr_done = 1'b1;
          case (act_e'(s_tuser_i))
            ACT_SET_POS: cmd_o.setpos = 1'b1;
            ACT_STOP:    cmd_o.stop = 1'b1;
            ACT_SET_TGT: begin
              cmd_o.latch_tgt = 1'b1;
              cnt_d = '0;
              state_d = S_SQ;
            end
            ACT_TICK: begin
              if (sts_i.active) begin
                cmd_o.tick = 1'b1;
                state_d = S_TCHK;
              end else begin
                state_d = S_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(2)) state_d = S_SQI;
      end
      S_SQI: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) state_d = S_NEAR;
      end
      S_NEAR: begin
        if (sts_i.dist_le1) begin
          cmd_o.near = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.mul = 1'b1;
          state_d = S_DLD;
        end
      end
      S_DLD: begin
        cmd_o.div_ld_time = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(PROD_W - 1)) state_d = S_SEG;
      end
      S_SEG: begin
        cmd_o.seg_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_TCHK: begin
        cnt_d = '0;
        if (sts_i.seg_zero) begin
          cmd_o.jump = 1'b1;
          state_d = S_OUT;
        end else if (sts_i.el_ge_seg) begin
          cmd_o.t_one = 1'b1;
          state_d = S_LERP;
        end else begin
          cmd_o.div_ld_t = 1'b1;
          state_d = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(FRAC_W - 1)) state_d = S_TQ;
      end
      S_TQ: begin
        cmd_o.t_quot = 1'b1;
        cnt_d = '0;
        state_d = S_LERP;
      end
      S_LERP: begin
        cmd_o.lerp = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(2)) state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register is free
        if (!mvalid_q || m_tready_i) begin
          cmd_o.emit = 1'b1;
          mvalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      mvalid_q <= mvalid_d;
    end
  end

endmodule

// ===== design/ltip_dp.sv =====
module ltip_dp import ltip_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ltip_cmd_t               cmd_i,
  input  logic signed [POS_W-1:0] in_x_i,
  input  logic signed [POS_W-1:0] in_y_i,
  input  logic signed [POS_W-1:0] in_z_i,
  input  logic [SPD_W-1:0]        in_speed_i,
  input  logic                    cfg_we_i,
  input  logic [PER_W-1:0]        cfg_data_i,
  output ltip_sts_t               sts_o,
  output logic signed [POS_W-1:0] out_x_o,
  output logic signed [POS_W-1:0] out_y_o,
  output logic signed [POS_W-1:0] out_z_o,
  output logic                    out_done_o,
  output logic                    out_moving_o
);

  logic signed [POS_W-1:0] start_q [3];
  logic signed [POS_W-1:0] end_q [3];
  logic signed [POS_W-1:0] sp_q [3];
  logic [TIME_W-1:0]       seg_q, el_q;
  logic                    active_q, done_q;
  logic [PER_W-1:0]        period_q;

  logic [SPD_W-1:0]  speed_q;
  logic [SQ_W-1:0]   acc_q, n_q, root_q, bit_q;
  logic [PROD_W-1:0] prod_q, num_q, quo_q;
  logic [TIME_W-1:0] rem_q, dvs_q;
  logic [T_W-1:0]    t_q;

  logic signed [DIF_W-1:0]  diff;
  logic [DIF_W-1:0]         absd;
  logic [SQ_W-1:0]          sq, sq_trial;
  logic                     sq_ge;
  logic [TIME_W:0]          dv_trial, el_sum;
  logic                     dv_ge;
  logic [PER_W-1:0]         per_eff;
  logic [TIME_W-1:0]        el_next, seg_sat;
  logic [SPD_W-1:0]         speed_eff;
  logic signed [LMUL_W-1:0] lmul, lsum;
  logic [1:0]               ax;

  assign ax   = cmd_i.axis;
  assign diff = DIF_W'(end_q[ax]) - DIF_W'(start_q[ax]);
  assign absd = diff[DIF_W-1] ? DIF_W'(-diff) : DIF_W'(diff);
  assign sq   = SQ_W'(absd) * SQ_W'(absd);

  assign sq_trial = root_q + bit_q;
  assign sq_ge    = (n_q >= sq_trial);

  assign dv_trial = {rem_q, num_q[PROD_W-1]};
  assign dv_ge    = (dv_trial >= {1'b0, dvs_q});

  assign per_eff = (period_q == '0) ? PERIOD_DEFAULT : period_q;
  assign el_sum  = {1'b0, el_q} + (TIME_W+1)'(per_eff);
  assign el_next = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];

  assign speed_eff = (speed_q <= SPD_W'(1)) ? SPEED_FLOOR : speed_q;
  assign seg_sat   = (|quo_q[PROD_W-1:TIME_W]) ? '1 : quo_q[TIME_W-1:0];

  // floor of d*t / 2^FRAC by arithmetic shift
  assign lmul = LMUL_W'(diff) * LMUL_W'($signed({1'b0, t_q}));
  assign lsum = (lmul >>> FRAC_W) + LMUL_W'(start_q[ax]);

  assign sts_o.active    = active_q;
  assign sts_o.dist_le1  = (root_q <= SQ_W'(1));
  assign sts_o.seg_zero  = (seg_q == '0);
  assign sts_o.el_ge_seg = (el_q >= seg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
        sp_q[i]    <= '0;
      end
      seg_q    <= '0;
      el_q     <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
      period_q <= PERIOD_DEFAULT;
    end else begin
      if (cfg_we_i) period_q <= cfg_data_i;
      if (cmd_i.clr_done) done_q <= 1'b0;
      if (cmd_i.setpos) begin
        sp_q[0] <= in_x_i;
        sp_q[1] <= in_y_i;
        sp_q[2] <= in_z_i;
      end
      if (cmd_i.stop) active_q <= 1'b0;
      if (cmd_i.latch_tgt) begin
        for (int i = 0; i < 3; i++) start_q[i] <= sp_q[i];
        end_q[0] <= in_x_i;
        end_q[1] <= in_y_i;
        end_q[2] <= in_z_i;
        el_q     <= '0;
      end
      if (cmd_i.tick) el_q <= el_next;
      if (cmd_i.near || cmd_i.jump) begin
        for (int i = 0; i < 3; i++) sp_q[i] <= end_q[i];
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
      if (cmd_i.near) seg_q <= '0;
      if (cmd_i.seg_wr) begin
        seg_q    <= seg_sat;
        active_q <= 1'b1;
      end
      if (cmd_i.lerp) sp_q[ax] <= lsum[POS_W-1:0];
      if (cmd_i.fin && (t_q == T_ONE)) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_tgt) speed_q <= in_speed_i;
    if (cmd_i.sq) acc_q <= (ax == 2'd0) ? sq : acc_q + sq;
    if (cmd_i.sqrt_init) begin
      n_q    <= acc_q;
      root_q <= '0;
      bit_q  <= SQ_W'(1) << (SQ_W - 2);
    end
    if (cmd_i.sqrt_step) begin
      if (sq_ge) begin
        n_q    <= n_q - sq_trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.mul) prod_q <= PROD_W'(root_q[ROOT_W-1:0]) * PROD_W'(USEC_PER_S);
    if (cmd_i.div_ld_time) begin
      num_q <= prod_q;
      rem_q <= '0;
      dvs_q <= TIME_W'(speed_eff);
      quo_q <= '0;
    end
    if (cmd_i.div_ld_t) begin
      num_q <= '0;
      rem_q <= el_q;
      dvs_q <= seg_q;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= dv_ge ? TIME_W'(dv_trial - {1'b0, dvs_q}) : dv_trial[TIME_W-1:0];
      quo_q <= {quo_q[PROD_W-2:0], dv_ge};
      num_q <= num_q << 1;
    end
    if (cmd_i.t_one) t_q <= T_ONE;
    if (cmd_i.t_quot) t_q <= {1'b0, quo_q[FRAC_W-1:0]};
    if (cmd_i.emit) begin
      out_x_o      <= sp_q[0];
      out_y_o      <= sp_q[1];
      out_z_o      <= sp_q[2];
      out_done_o   <= done_q;
      out_moving_o <= active_q;
    end
  end

endmodule

// ===== design/linear_trajectory_interpolator.sv =====
// Straight-line setpoint interpolator in micrometres, three axes.
// Input stream: s_tuser carries the command (set position, set target,
// stop, tick), s_tdata the coordinates and path speed. Output stream:
// m_tdata the setpoint, m_tlast marks the end of a segment, m_tuser
// says a segment is still in progress. Ticks always return one setpoint;
// a set target returns one only when the move is shorter than 2 um.
// cfg_* writes the control period in us (0 acts as 5000); write it idle.
// Set position and stop finish on acceptance; set target runs 3 square
// steps, a 25-step square root and a 45-step divide for the segment
// time, or skips the multiply and divide when the move is too short and
// the target is returned at once; an active tick runs a 16-step divide
// for the fraction and 3 shared lerp multiplies, skips the divide once
// elapsed reaches the segment time and both for a zero segment time.
// One item at a time; the shared shift-subtract divider sets the pace.
// The output register holds a result while m_tready is low; the next item
// is taken meanwhile and its result waits until the register frees up.
// Reset clears the stored positions (not the output register), timers
// and the active flag and sets the period to 5000 us.
module linear_trajectory_interpolator import ltip_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [95:0]       s_tdata,   // pos_x, pos_y, pos_z, speed_um_s
  input  logic [1:0]        s_tuser,   // action
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [71:0]       m_tdata,   // set_x, set_y, set_z
  output logic              m_tlast,   // done_res
  output logic              m_tuser,   // moving
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [PER_W-1:0]  cfg_data_i
);

  ltip_cmd_t cmd;
  ltip_sts_t sts;
  logic signed [POS_W-1:0] ox, oy, oz;

  assign cfg_ready_o = 1'b1;

  ltip_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tuser_i  (s_tuser),
    .m_tready_i (m_tready),
    .sts_i      (sts),
    .s_tready_o (s_tready),
    .m_tvalid_o (m_tvalid),
    .cmd_o      (cmd)
  );

  ltip_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .in_x_i       (s_tdata[23:0]),
    .in_y_i       (s_tdata[47:24]),
    .in_z_i       (s_tdata[71:48]),
    .in_speed_i   (s_tdata[95:72]),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .sts_o        (sts),
    .out_x_o      (ox),
    .out_y_o      (oy),
    .out_z_o      (oz),
    .out_done_o   (m_tlast),
    .out_moving_o (m_tuser)
  );

  assign m_tdata = {oz, oy, ox};

`ifndef SYNTH
  a_done_not_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("segment end reported while still moving");
  a_target_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && (s_tuser == ACT_SET_TGT) |=> !s_tready)
    else $error("input taken during target setup");
  a_pos_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_tvalid && s_tvalid && s_tready && (s_tuser == ACT_SET_POS) |=> !m_tvalid)
    else $error("set position produced a result");
`endif

endmodule

// ===== verif/tb_linear_trajectory_interpolator.sv =====
module tb_linear_trajectory_interpolator;
  import ltip_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic        done;
    logic        moving;
  } setpt_t;

  typedef struct {
    act_e        act;
    logic [23:0] px, py, pz, spd;
    bit          has_gold;
    setpt_t      gold;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = ACT_STOP;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [71:0] m_tdata;
  wire         m_tlast;
  wire         m_tuser;
  logic        cfg_valid_i = 1'b0;
  wire         cfg_ready_o;
  logic [PER_W-1:0] cfg_data_i = '0;

  linear_trajectory_interpolator DUT (.*);

  // predictor state
  longint      p_start[3], p_end[3], p_set[3];
  longint unsigned p_seg, p_el;
  bit          p_active;
  longint unsigned p_period;

  setpt_t      setpt_q[$];
  int          n_err = 0;
  int          src_idle = 25, snk_idle = 51;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic setpt_t pack_setpt(bit done);
    setpt_t s;
    s.x = p_set[0][23:0];
    s.y = p_set[1][23:0];
    s.z = p_set[2][23:0];
    s.done = done;
    s.moving = p_active;
    return s;
  endfunction

  // advance the predictor by one command, queue any expected setpoint
  task automatic predict_setpt(act_e act, logic [23:0] px, py, pz, spd);
    longint pos[3];
    longint unsigned sum, dlen, tm, sp, e, t, one;
    longint d, p, q;
    bit done;
    pos[0] = sx24(px); pos[1] = sx24(py); pos[2] = sx24(pz);
    one = 64'd1 << 16;
    case (act)
      ACT_SET_POS: for (int i = 0; i < 3; i++) p_set[i] = pos[i];
      ACT_SET_TGT: begin
        sp = (spd <= 1) ? 64'd10000 : 64'(spd);
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          p_start[i] = p_set[i];
          p_end[i] = pos[i];
          d = p_end[i] - p_start[i];
          if (d < 0) d = -d;
          sum += d * d;
        end
        dlen = root_floor(sum);
        p_el = 0;
        if (dlen <= 1) begin
          p_seg = 0;
          p_active = 0;
          for (int i = 0; i < 3; i++) p_set[i] = p_end[i];
          setpt_q.push_back(pack_setpt(1));
        end else begin
          tm = dlen * 1000000 / sp;
          p_seg = (tm > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : tm;
          p_active = 1;
        end
      end
      ACT_STOP: p_active = 0;
      default: begin
        done = 0;
        if (p_active) begin
          e = p_el + ((p_period == 0) ? 64'd5000 : p_period);
          p_el = (e > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : e;
          if (p_seg == 0) begin
            for (int i = 0; i < 3; i++) p_set[i] = p_end[i];
            p_active = 0;
            done = 1;
          end else begin
            t = (p_el << 16) / p_seg;
            if (t > one) t = one;
            for (int i = 0; i < 3; i++) begin
              p = (p_end[i] - p_start[i]) * longint'(t);
              q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
              p_set[i] = sx24(24'(p_start[i] + q));
            end
            if (t == one) begin
              p_active = 0;
              done = 1;
            end
          end
        end
        setpt_q.push_back(pack_setpt(done));
      end
    endcase
  endtask

  // hold valid low while idling, then hold the transfer until it is taken
  task automatic send_cmd(act_e act, logic [23:0] px, py, pz, spd);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= {spd, pz, py, px};
    predict_setpt(act, px, py, pz, spd);
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain();
    int guard = 0;
    s_tvalid <= 1'b0;
    while (setpt_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_period(logic [PER_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    p_period = v;
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    setpt_t got, want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[23:0], m_tdata[47:24], m_tdata[71:48], m_tlast, m_tuser};
        if (setpt_q.size() == 0) begin
          $error("setpoint with no command pending");
          n_err++;
        end else begin
          want = setpt_q.pop_front();
          if (got.x != want.x) begin
            $error("set_x exp %h got %h", want.x, got.x); n_err++;
          end
          if (got.y != want.y) begin
            $error("set_y exp %h got %h", want.y, got.y); n_err++;
          end
          if (got.z != want.z) begin
            $error("set_z exp %h got %h", want.z, got.z); n_err++;
          end
          if (got.done != want.done) begin
            $error("done_res exp %b got %b", want.done, got.done); n_err++;
          end
          if (got.moving != want.moving) begin
            $error("moving exp %b got %b", want.moving, got.moving); n_err++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= snk_idle);
    end
  end

  task automatic rand_cmd();
    int r;
    logic [23:0] px, py, pz, spd;
    r = $urandom_range(99);
    px = 24'($urandom); py = 24'($urandom); pz = 24'($urandom);
    // keep most moves short so segments finish in a handful of ticks
    if ($urandom_range(3) != 0) begin
      px = 24'(sx24(p_set[0][23:0]) + $signed(32'($urandom_range(4000)) - 2000));
      py = 24'(sx24(p_set[1][23:0]) + $signed(32'($urandom_range(4000)) - 2000));
      pz = 24'(sx24(p_set[2][23:0]) + $signed(32'($urandom_range(4000)) - 2000));
    end
    if ($urandom_range(9) == 0) begin
      px = p_set[0][23:0] + 24'($urandom_range(1));
      py = p_set[1][23:0];
      pz = p_set[2][23:0];
    end
    case ($urandom_range(4))
      0: spd = 24'($urandom_range(1));
      1: spd = 24'($urandom);
      default: spd = 24'($urandom_range(2000000, 100000));
    endcase
    if (r < 8) send_cmd(ACT_SET_POS, px, py, pz, spd);
    else if (r < 20) send_cmd(ACT_SET_TGT, px, py, pz, spd);
    else if (r < 23) send_cmd(ACT_STOP, px, py, pz, spd);
    else send_cmd(ACT_TICK, px, py, pz, spd);
  endtask

  dir_row_t dir_tab[$];

  function automatic dir_row_t row(act_e a, logic [23:0] x, y, z, s, bit hg,
                                   setpt_t g);
    dir_row_t r;
    r.act = a; r.px = x; r.py = y; r.pz = z; r.spd = s; r.has_gold = hg; r.gold = g;
    return r;
  endfunction

  initial begin
    setpt_t none;
    none = '0;
    for (int i = 0; i < 3; i++) begin
      p_start[i] = 0; p_end[i] = 0; p_set[i] = 0;
    end
    p_seg = 0; p_el = 0; p_active = 0; p_period = 5000;

    dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0}));
    dir_tab.push_back(row(ACT_SET_TGT, 1, 0, 0, 0, 1, '{24'd1, 0, 0, 1, 0}));
    dir_tab.push_back(row(ACT_SET_POS, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 0, none));
    dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 1,
                          '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 0}));
    dir_tab.push_back(row(ACT_SET_TGT, 24'h800000, 24'h7FFFFF, 24'h800000,
                          24'hFFFFFF, 0, none));
    for (int i = 0; i < 4; i++) dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 0, none));
    dir_tab.push_back(row(ACT_SET_TGT, 24'h001000, 0, 0, 1, 0, none));
    dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 0, none));
    dir_tab.push_back(row(ACT_STOP, 0, 0, 0, 0, 0, none));
    dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 0, none));
    dir_tab.push_back(row(ACT_SET_POS, 0, 0, 0, 0, 0, none));
    dir_tab.push_back(row(ACT_SET_TGT, 24'd100, 24'd200, 24'hFFFF00, 24'd50, 0, none));
    for (int i = 0; i < 3; i++) dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 0, none));
    // tiny speed: segment time saturates
    dir_tab.push_back(row(ACT_SET_TGT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'd2, 0, none));
    dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 0, none));
    dir_tab.push_back(row(ACT_SET_TGT, 24'd2, 0, 0, 24'hFFFFFF, 0, none));
    dir_tab.push_back(row(ACT_TICK, 0, 0, 0, 0, 0, none));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].has_gold) begin
        send_cmd(dir_tab[k].act, dir_tab[k].px, dir_tab[k].py, dir_tab[k].pz,
                 dir_tab[k].spd);
        setpt_q[setpt_q.size()-1] = dir_tab[k].gold;
      end else begin
        send_cmd(dir_tab[k].act, dir_tab[k].px, dir_tab[k].py, dir_tab[k].pz,
                 dir_tab[k].spd);
      end
    end
    drain();

    // period extremes: zero acts as default, full scale used as written
    write_period('0);
    for (int k = 0; k < 60; k++) rand_cmd();
    drain();
    write_period(20'hFFFFF);
    for (int k = 0; k < 60; k++) rand_cmd();
    drain();
    write_period(20'd1);
    for (int k = 0; k < 40; k++) rand_cmd();
    drain();

    src_idle = 51; snk_idle = 25;
    write_period(20'd1000);
    for (int k = 0; k < 330; k++) rand_cmd();
    drain();

    write_period(20'd250000);
    for (int k = 0; k < 330; k++) rand_cmd();
    drain();

    src_idle = 0; snk_idle = 0;
    write_period(20'($urandom_range(1000000, 1)));
    for (int k = 0; k < 330; k++) rand_cmd();
    drain();

    if (n_err == 0 && setpt_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/ltip_pkg.sv
design/ltip_ctrl.sv
design/ltip_dp.sv
design/linear_trajectory_interpolator.sv
verif/tb_linear_trajectory_interpolator.sv
